FILE: design/hti_pkg.sv
// Shared types, widths and codes for the heightmap triangle interpolator.
package hti_pkg;

    // Field widths
    localparam int DIM_W      = 9;
    localparam int INV_W      = 24;
    localparam int HGT_W      = 16;
    localparam int POS_W      = 24;
    localparam int OUT_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 24;

    // Datapath widths
    localparam int FRAC_BITS = 16;
    localparam int CXW       = 41;          // cell coordinate, signed Q24.16
    localparam int MULW      = 25;          // multiplier operand
    localparam int GLO_W     = MULW - 1;    // low slice of a fraction
    localparam int PRODW     = 2 * MULW;
    localparam int DIFFW     = HGT_W + 1;
    localparam int ACCW      = 60;

    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int HEIGHT_MAX = 524287;
    localparam int HEIGHT_MIN = -524288;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_DISTANCE = 2'd2;

    localparam logic [DIM_W-1:0] NUM_COLS_RST = 9'd256;
    localparam logic [DIM_W-1:0] NUM_ROWS_RST = 9'd256;
    localparam logic [INV_W-1:0] INV_CELL_RST = 24'd6554;

    // Item kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MUL_X,
        ST_MUL_Z,
        ST_CELL_Z,
        ST_CELL,
        ST_FRAC,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_RD_W,
        ST_DIFF,
        ST_MAC_1,
        ST_MAC_2,
        ST_MAC_3,
        ST_MAC_4,
        ST_MAC_5,
        ST_DONE
    } hti_state_t;

    typedef enum logic [2:0] {
        MUL_POS_X,
        MUL_POS_Z,
        MUL_D1_LO,
        MUL_D1_HI,
        MUL_D2_LO,
        MUL_D2_HI
    } hti_mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_ADD_LO,
        ACC_ADD_HI
    } hti_acc_op_t;

    // Corner of the cell: A upper left, B upper right, C lower left, D lower right
    typedef enum logic [1:0] {
        VTX_A,
        VTX_B,
        VTX_C,
        VTX_D
    } hti_vtx_t;

    typedef struct packed {
        logic         ld_in;
        logic         ram_we;
        logic         ram_re;
        hti_vtx_t     rd_vtx;
        logic         cap_en;
        hti_vtx_t     cap_vtx;
        logic         ld_cx;
        logic         ld_cz;
        logic         ld_cell;
        logic         ld_frac;
        logic         ld_diff;
        hti_mul_sel_t mul_sel;
        hti_acc_op_t  acc_op;
        logic         ld_out;
    } hti_cmd_t;

endpackage

FILE: design/heightmap_triangle_interpolator.sv
// Top level: configuration registers, controller and datapath of the heightmap interpolator.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata: row, col, height_value, pos_x, pos_z; s_tuser: func
//  m_       out  m_tvalid/m_tready    m_tdata: height; m_tuser: clamped
//  cfg_     in   cfg_wr_en            cfg_index, cfg_wr_data
//
// Transactions are handled one at a time: the next one is taken only after a write is stored
// or a query has reached the output register while the result side is free; the pace is set
// by the one read port of the height store (four corner reads) and the one shared 25x25
// multiplier (two position and four partial products).
// A finished result sits in the output register; the next transaction is taken meanwhile
// and a further result stalls only in its last state until that register is free.
// Reset (aresetn, synchronous) clears the controller and restores the register defaults;
// the height store is not cleared.
module heightmap_triangle_interpolator import hti_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // row[7:0], col[15:8], height_value[31:16],
                                              // pos_x[55:32], pos_z[79:56]
    input  logic                  s_tuser,    // func[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // height[19:0], zero fill [23:20]
    output logic                  m_tuser,    // clamped[0]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [DIM_W-1:0] num_cols_reg, num_rows_reg;
    logic [INV_W-1:0] inv_cell_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= NUM_COLS_RST;
            num_rows_reg <= NUM_ROWS_RST;
            inv_cell_reg <= INV_CELL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUM_COLS:          num_cols_reg <= cfg_wr_data[DIM_W-1:0];
                CFG_NUM_ROWS:          num_rows_reg <= cfg_wr_data[DIM_W-1:0];
                CFG_INV_CELL_DISTANCE: inv_cell_reg <= cfg_wr_data[INV_W-1:0];
                default:               ;
            endcase
        end
    end

    hti_cmd_t                cmd;
    logic signed [OUT_W-1:0] height;
    logic                    clamped;

    hti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    hti_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_row            (s_tdata[7:0]),
        .in_col            (s_tdata[15:8]),
        .in_height_value   ($signed(s_tdata[31:16])),
        .in_pos_x          ($signed(s_tdata[55:32])),
        .in_pos_z          ($signed(s_tdata[79:56])),
        .num_cols          (num_cols_reg),
        .num_rows          (num_rows_reg),
        .inv_cell_distance (inv_cell_reg),
        .out_height        (height),
        .out_clamped       (clamped)
    );

    assign m_tdata = M_TDATA_W'($unsigned(height));
    assign m_tuser = clamped;

endmodule

FILE: design/hti_ram.sv
// Single-port RAM with registered read.
module hti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: design/hti_datapath.sv
// Datapath: input latch, shared multiplier, cell and fraction logic, height store, accumulator.
module hti_datapath import hti_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hti_cmd_t                cmd,
    input  logic [7:0]              in_row,
    input  logic [7:0]              in_col,
    input  logic signed [HGT_W-1:0] in_height_value,
    input  logic signed [POS_W-1:0] in_pos_x,
    input  logic signed [POS_W-1:0] in_pos_z,
    input  logic [DIM_W-1:0]        num_cols,
    input  logic [DIM_W-1:0]        num_rows,
    input  logic [INV_W-1:0]        inv_cell_distance,
    output logic signed [OUT_W-1:0] out_height,
    output logic                    out_clamped
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int NCW   = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
    localparam int NRW   = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
    localparam int CIW   = ((CW > 8) ? CW : 8) + 1;
    localparam int RIW   = ((RW > 8) ? RW : 8) + 1;
    localparam int CFW   = CXW - FRAC_BITS;
    localparam int SUMW  = CXW + 1;

    // Latched input transaction
    logic [7:0]              row_in_reg;
    logic [7:0]              col_in_reg;
    logic signed [HGT_W-1:0] hv_in_reg;
    logic signed [POS_W-1:0] px_in_reg;
    logic signed [POS_W-1:0] pz_in_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            row_in_reg <= in_row;
            col_in_reg <= in_col;
            hv_in_reg  <= in_height_value;
            px_in_reg  <= in_pos_x;
            pz_in_reg  <= in_pos_z;
        end
    end

    // Grid size held clamped to the store, with its derived limits and offsets
    logic [NCW-1:0]        nc_next, lim_c_reg;
    logic [NRW-1:0]        nr_next, lim_r_reg;
    logic signed [CXW-1:0] off_x_reg, off_z_reg;

    always_comb begin
        nc_next = NCW'(num_cols);
        if (nc_next < NCW'(2)) begin
            nc_next = NCW'(2);
        end else if (nc_next > NCW'(MAX_COLS)) begin
            nc_next = NCW'(MAX_COLS);
        end
        nr_next = NRW'(num_rows);
        if (nr_next < NRW'(2)) begin
            nr_next = NRW'(2);
        end else if (nr_next > NRW'(MAX_ROWS)) begin
            nr_next = NRW'(MAX_ROWS);
        end
    end

    always_ff @(posedge aclk) begin
        lim_c_reg <= nc_next - NCW'(2);
        lim_r_reg <= nr_next - NRW'(2);
        off_x_reg <= $signed(CXW'(nc_next - NCW'(1)) << (FRAC_BITS - 1));
        off_z_reg <= $signed(CXW'(nr_next - NRW'(1)) << (FRAC_BITS - 1));
    end

    // Shared multiplier, product registered
    logic signed [DIFFW-1:0] d1_reg, d2_reg;
    logic signed [CXW-1:0]   gx_reg, gz_reg;
    logic signed [MULW-1:0]  ma, mb;
    logic signed [PRODW-1:0] prod_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_POS_X: begin
                ma = MULW'(px_in_reg);
                mb = $signed(MULW'(inv_cell_distance));
            end
            MUL_POS_Z: begin
                ma = MULW'(pz_in_reg);
                mb = $signed(MULW'(inv_cell_distance));
            end
            MUL_D1_LO: begin
                ma = MULW'(d1_reg);
                mb = $signed(MULW'(gx_reg[GLO_W-1:0]));
            end
            MUL_D1_HI: begin
                ma = MULW'(d1_reg);
                mb = MULW'($signed(gx_reg[CXW-1:GLO_W]));
            end
            MUL_D2_LO: begin
                ma = MULW'(d2_reg);
                mb = $signed(MULW'(gz_reg[GLO_W-1:0]));
            end
            MUL_D2_HI: begin
                ma = MULW'(d2_reg);
                mb = MULW'($signed(gz_reg[CXW-1:GLO_W]));
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
    end

    // Cell coordinates: floor the Q.24 product to Q.16, then offset by half the grid
    logic signed [CXW-1:0] cx_reg, cz_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ld_cx) begin
            cx_reg <= CXW'(prod_reg >>> 8) + off_x_reg;
        end
        if (cmd.ld_cz) begin
            cz_reg <= off_z_reg - CXW'(prod_reg >>> 8);
        end
    end

    // Cell index, clamped to the grid
    logic signed [CFW-1:0] col_f, row_f;
    logic [CW-1:0]         col_next, col_reg;
    logic [RW-1:0]         row_next, row_reg;
    logic                  clamp_c, clamp_r, clamped_reg;

    always_comb begin
        col_f   = $signed(cx_reg[CXW-1:FRAC_BITS]);
        row_f   = $signed(cz_reg[CXW-1:FRAC_BITS]);
        clamp_c = 1'b0;
        clamp_r = 1'b0;
        col_next = col_f[CW-1:0];
        row_next = row_f[RW-1:0];
        if (col_f < 0) begin
            col_next = '0;
            clamp_c  = 1'b1;
        end else if (col_f > $signed(CFW'(lim_c_reg))) begin
            col_next = CW'(lim_c_reg);
            clamp_c  = 1'b1;
        end
        if (row_f < 0) begin
            row_next = '0;
            clamp_r  = 1'b1;
        end else if (row_f > $signed(CFW'(lim_r_reg))) begin
            row_next = RW'(lim_r_reg);
            clamp_r  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_cell) begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            clamped_reg <= clamp_c | clamp_r;
        end
    end

    // Fractions against the clamped cell; these are not clamped
    logic signed [CXW-1:0]  fx_reg, fz_reg, nfx_reg, nfz_reg;
    logic signed [SUMW-1:0] fsum;
    logic                   lower_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ld_frac) begin
            fx_reg <= cx_reg - $signed(CXW'(col_reg) << FRAC_BITS);
            fz_reg <= cz_reg - $signed(CXW'(row_reg) << FRAC_BITS);
        end
    end

    assign fsum = SUMW'(fx_reg) + SUMW'(fz_reg);

    // Follow the fractions: the triangle choice and complements are registered from them, gx and gz from those
    always_ff @(posedge aclk) begin
        lower_reg <= fsum < SUMW'(ONE_Q);
        nfx_reg   <= CXW'(ONE_Q) - fx_reg;
        nfz_reg   <= CXW'(ONE_Q) - fz_reg;
        gx_reg    <= lower_reg ? fx_reg : nfx_reg;
        gz_reg    <= lower_reg ? fz_reg : nfz_reg;
    end

    // Height store
    logic [RIW-1:0]   row_w;
    logic [CIW-1:0]   col_w;
    logic             wr_ok;
    logic [RW-1:0]    rd_row;
    logic [CW-1:0]    rd_col;
    logic [AW-1:0]    ram_addr;
    logic [HGT_W-1:0] ram_rdata;

    assign row_w = RIW'(row_in_reg);
    assign col_w = CIW'(col_in_reg);
    assign wr_ok = (row_w < RIW'(MAX_ROWS)) && (col_w < CIW'(MAX_COLS));

    always_comb begin
        rd_row = row_reg;
        rd_col = col_reg;
        case (cmd.rd_vtx)
            VTX_A: ;
            VTX_B: rd_col = col_reg + CW'(1);
            VTX_C: rd_row = row_reg + RW'(1);
            VTX_D: begin
                rd_row = row_reg + RW'(1);
                rd_col = col_reg + CW'(1);
            end
            default: ;
        endcase
        ram_addr = cmd.ram_we ? {row_w[RW-1:0], col_w[CW-1:0]} : {rd_row, rd_col};
    end

    hti_ram #(
        .WIDTH (HGT_W),
        .DEPTH (1 << AW)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.ram_we & wr_ok),
        .re    (cmd.ram_re),
        .addr  (ram_addr),
        .wdata (hv_in_reg),
        .rdata (ram_rdata)
    );

    // Corner heights
    logic signed [HGT_W-1:0] a_reg, b_reg, c_reg, d_reg, base_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            case (cmd.cap_vtx)
                VTX_A:   a_reg <= $signed(ram_rdata);
                VTX_B:   b_reg <= $signed(ram_rdata);
                VTX_C:   c_reg <= $signed(ram_rdata);
                VTX_D:   d_reg <= $signed(ram_rdata);
                default: ;
            endcase
        end
    end

    // Pick the triangle: upper left from A, lower right from D
    always_ff @(posedge aclk) begin
        if (cmd.ld_diff) begin
            if (lower_reg) begin
                base_reg <= a_reg;
                d1_reg   <= DIFFW'(b_reg) - DIFFW'(a_reg);
                d2_reg   <= DIFFW'(c_reg) - DIFFW'(a_reg);
            end else begin
                base_reg <= d_reg;
                d1_reg   <= DIFFW'(c_reg) - DIFFW'(d_reg);
                d2_reg   <= DIFFW'(b_reg) - DIFFW'(d_reg);
            end
        end
    end

    // Accumulate exactly in Q.16; high partial products weigh 2^24
    logic signed [ACCW-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        case (cmd.acc_op)
            ACC_HOLD:   ;
            ACC_INIT:   acc_reg <= ACCW'(base_reg) <<< FRAC_BITS;
            ACC_ADD_LO: acc_reg <= acc_reg + ACCW'(prod_reg);
            ACC_ADD_HI: acc_reg <= acc_reg + (ACCW'(prod_reg) <<< GLO_W);
            default:    ;
        endcase
    end

    // Round half up, floor to an integer and saturate
    logic signed [ACCW-1:0]  acc_rnd;
    logic signed [OUT_W-1:0] height_sat;

    always_comb begin
        acc_rnd = (acc_reg + ACCW'(ONE_Q / 2)) >>> FRAC_BITS;
        if (acc_rnd > ACCW'(HEIGHT_MAX)) begin
            height_sat = OUT_W'(HEIGHT_MAX);
        end else if (acc_rnd < ACCW'(HEIGHT_MIN)) begin
            height_sat = OUT_W'(HEIGHT_MIN);
        end else begin
            height_sat = acc_rnd[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            out_height  <= height_sat;
            out_clamped <= clamped_reg;
        end
    end

    a_col_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_cell |=> NCW'(col_reg) <= lim_c_reg)
        else $error("cell column beyond grid edge");

    a_row_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_cell |=> NRW'(row_reg) <= lim_r_reg)
        else $error("cell row beyond grid edge");

endmodule

FILE: design/hti_ctrl.sv
// Controller: sequences one transaction at a time through the datapath and owns the result valid.
module hti_ctrl import hti_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tuser,
    output logic     s_tready,
    input  logic     m_tready,
    output logic     m_tvalid,
    output hti_cmd_t cmd
);

    hti_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = MUL_POS_X;
        cmd.acc_op    = ACC_HOLD;
        cmd.rd_vtx    = VTX_A;
        cmd.cap_vtx   = VTX_A;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = (s_tuser == FUNC_QUERY) ? ST_MUL_X : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.ram_we = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MUL_X: begin
                cmd.mul_sel = MUL_POS_X;
                state_next  = ST_MUL_Z;
            end
            ST_MUL_Z: begin
                cmd.mul_sel = MUL_POS_Z;
                cmd.ld_cx   = 1'b1;
                state_next  = ST_CELL_Z;
            end
            ST_CELL_Z: begin
                cmd.ld_cz  = 1'b1;
                state_next = ST_CELL;
            end
            ST_CELL: begin
                cmd.ld_cell = 1'b1;
                state_next  = ST_FRAC;
            end
            ST_FRAC: begin
                cmd.ld_frac = 1'b1;
                cmd.ram_re  = 1'b1;
                cmd.rd_vtx  = VTX_A;
                state_next  = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.ram_re  = 1'b1;
                cmd.rd_vtx  = VTX_B;
                cmd.cap_en  = 1'b1;
                cmd.cap_vtx = VTX_A;
                state_next  = ST_RD_C;
            end
            ST_RD_C: begin
                cmd.ram_re  = 1'b1;
                cmd.rd_vtx  = VTX_C;
                cmd.cap_en  = 1'b1;
                cmd.cap_vtx = VTX_B;
                state_next  = ST_RD_D;
            end
            ST_RD_D: begin
                cmd.ram_re  = 1'b1;
                cmd.rd_vtx  = VTX_D;
                cmd.cap_en  = 1'b1;
                cmd.cap_vtx = VTX_C;
                state_next  = ST_RD_W;
            end
            ST_RD_W: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_vtx = VTX_D;
                state_next  = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.ld_diff = 1'b1;
                state_next  = ST_MAC_1;
            end
            // Multiply one partial product while the previous one is added in
            ST_MAC_1: begin
                cmd.mul_sel = MUL_D1_LO;
                cmd.acc_op  = ACC_INIT;
                state_next  = ST_MAC_2;
            end
            ST_MAC_2: begin
                cmd.mul_sel = MUL_D1_HI;
                cmd.acc_op  = ACC_ADD_LO;
                state_next  = ST_MAC_3;
            end
            ST_MAC_3: begin
                cmd.mul_sel = MUL_D2_LO;
                cmd.acc_op  = ACC_ADD_HI;
                state_next  = ST_MAC_4;
            end
            ST_MAC_4: begin
                cmd.mul_sel = MUL_D2_HI;
                cmd.acc_op  = ACC_ADD_LO;
                state_next  = ST_MAC_5;
            end
            ST_MAC_5: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (slot_free) begin
                    cmd.ld_out    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken transaction");

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == FUNC_QUERY) |=> state_reg == ST_MUL_X)
        else $error("query transaction did not start the multiplier");

    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && slot_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished query gave no result");

    a_no_accept_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ld_in && cmd.ld_out))
        else $error("input latched while a result was loaded");

endmodule

FILE: dv/heightmap_triangle_interpolator_tb.sv
// Self-checking testbench for the heightmap triangle interpolator: writes, queries, grid settings.
module heightmap_triangle_interpolator_tb;
    import hti_pkg::*;

    localparam int GRID_COLS     = 256;
    localparam int GRID_ROWS     = 256;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct {
        logic        func;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] hval;
        logic [23:0] pos_x;
        logic [23:0] pos_z;
    } terrain_item_t;

    typedef struct {
        logic [OUT_W-1:0] height;
        logic             clamped;
    } height_due_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    heightmap_triangle_interpolator #(
        .MAX_COLS(GRID_COLS),
        .MAX_ROWS(GRID_ROWS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predicted register copies and height store
    logic [DIM_W-1:0]  cols_reg = NUM_COLS_RST;
    logic [DIM_W-1:0]  rows_reg = NUM_ROWS_RST;
    logic [INV_W-1:0]  inv_reg  = INV_CELL_RST;
    logic signed [HGT_W-1:0] height_mem [0:GRID_ROWS*GRID_COLS-1];
    bit                written_gen [0:GRID_ROWS*GRID_COLS-1];

    terrain_item_t terrain_items [$];
    height_due_t   heights_due [$];

    int mismatch_cnt  = 0;
    int writes_seen   = 0;
    int queries_seen  = 0;
    int clamped_seen  = 0;
    int lower_seen    = 0;
    int sat_seen      = 0;
    int results_seen  = 0;
    int settings_cnt  = 0;
    int items_queued  = 0;
    int hold_requested = 0;
    int hold_served    = 0;
    int cycle_cnt      = 0;

    function automatic int grid_dim(input logic [DIM_W-1:0] v, input int maxv);
        if (v < 2)
            return 2;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    // Map a world position to a clamped cell and its unclamped Q.16 coordinates.
    function automatic void locate_cell(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz,
                                        output longint cx, output longint cz,
                                        output longint col, output longint row,
                                        output bit clamped);
        longint ncols;
        longint nrows;
        longint inv;
        ncols = longint'(grid_dim(cols_reg, GRID_COLS));
        nrows = longint'(grid_dim(rows_reg, GRID_ROWS));
        inv   = longint'({40'd0, inv_reg});
        cx = ((longint'($signed(px)) * inv) >>> 8) + (ncols - 1) * (ONE_Q / 2);
        cz = (nrows - 1) * (ONE_Q / 2) - ((longint'($signed(pz)) * inv) >>> 8);
        col = cx >>> FRAC_BITS;
        row = cz >>> FRAC_BITS;
        clamped = 1'b0;
        if (col < 0) begin
            col = 0;
            clamped = 1'b1;
        end
        if (row < 0) begin
            row = 0;
            clamped = 1'b1;
        end
        if (col > ncols - 2) begin
            col = ncols - 2;
            clamped = 1'b1;
        end
        if (row > nrows - 2) begin
            row = nrows - 2;
            clamped = 1'b1;
        end
    endfunction

    function automatic longint stored_height(input longint row, input longint col);
        return longint'(height_mem[row * GRID_COLS + col]);
    endfunction

    // Take one accepted transaction into the prediction.
    function automatic void absorb_item(input terrain_item_t it);
        longint cx, cz, col, row, fx, fz, a, b, c, d, acc, h;
        bit clamped;
        height_due_t due;
        if (it.func == FUNC_WRITE) begin
            height_mem[{it.row, it.col}] = it.hval;
            writes_seen++;
            return;
        end
        locate_cell(it.pos_x, it.pos_z, cx, cz, col, row, clamped);
        fx = cx - col * ONE_Q;
        fz = cz - row * ONE_Q;
        a = stored_height(row, col);
        b = stored_height(row, col + 1);
        c = stored_height(row + 1, col);
        d = stored_height(row + 1, col + 1);
        if (fx + fz < ONE_Q) begin
            acc = a * ONE_Q + (b - a) * fx + (c - a) * fz;
        end else begin
            acc = d * ONE_Q + (c - d) * (ONE_Q - fx) + (b - d) * (ONE_Q - fz);
            lower_seen++;
        end
        h = (acc + ONE_Q / 2) >>> FRAC_BITS;
        if (h > HEIGHT_MAX || h < HEIGHT_MIN)
            sat_seen++;
        if (h > HEIGHT_MAX)
            h = longint'(HEIGHT_MAX);
        if (h < HEIGHT_MIN)
            h = longint'(HEIGHT_MIN);
        due.height  = h[OUT_W-1:0];
        due.clamped = clamped;
        heights_due.push_back(due);
        queries_seen++;
        if (clamped)
            clamped_seen++;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_cnt++;
    endtask

    // Sender: bursts of random length separated by random gaps
    terrain_item_t offered;
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_item(offered);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || terrain_items.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    offered = terrain_items.pop_front();
                    s_tdata  <= {offered.pos_z, offered.pos_x, offered.hval,
                                 offered.col, offered.row};
                    s_tuser  <= offered.func;
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: rotating ready pattern, refreshed now and then, plus requested long holds
    logic [15:0] ready_pattern = 16'hFFFF;
    int pattern_age = 0;
    int hold_left   = 0;
    height_due_t due_now;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (heights_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected: height %0d",
                                              results_seen, $signed(m_tdata[OUT_W-1:0])));
                end else begin
                    due_now = heights_due.pop_front();
                    if (m_tdata[OUT_W-1:0] !== due_now.height)
                        report_mismatch($sformatf("result %0d height %0d, expected %0d",
                                                  results_seen,
                                                  $signed(m_tdata[OUT_W-1:0]),
                                                  $signed(due_now.height)));
                    if (m_tuser !== due_now.clamped)
                        report_mismatch($sformatf("result %0d clamped %0b, expected %0b",
                                                  results_seen, m_tuser, due_now.clamped));
                end
            end
            if (hold_served != hold_requested) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                pattern_age++;
                if (pattern_age == 64) begin
                    pattern_age = 0;
                    ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                : (16'($urandom) | 16'h0001);
                end
                ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
                m_tready <= ready_pattern[0];
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, heights_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus generation
    function automatic logic [HGT_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_write(input int row, input int col, input logic [15:0] value);
        terrain_item_t it;
        it.func  = FUNC_WRITE;
        it.row   = row[7:0];
        it.col   = col[7:0];
        it.hval  = value;
        it.pos_x = 24'($urandom);
        it.pos_z = 24'($urandom);
        written_gen[{it.row, it.col}] = 1'b1;
        terrain_items.push_back(it);
        items_queued++;
    endfunction

    // Fill in any unwritten corner of the target cell before the query itself.
    function automatic void queue_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        terrain_item_t it;
        longint cx, cz, col, row;
        bit clamped;
        locate_cell(px, pz, cx, cz, col, row, clamped);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
                if (!written_gen[(row + r) * GRID_COLS + col + c])
                    queue_write(int'(row) + r, int'(col) + c, pick_height());
        it.func  = FUNC_QUERY;
        it.row   = 8'($urandom);
        it.col   = 8'($urandom);
        it.hval  = 16'($urandom);
        it.pos_x = px;
        it.pos_z = pz;
        terrain_items.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [POS_W-1:0] fit_position(input longint p);
        if (p > 64'sd8388607)
            return 24'h7FFFFF;
        if (p < -64'sd8388608)
            return 24'h800000;
        return p[POS_W-1:0];
    endfunction

    // Aim a query at a chosen cell and fraction; outside lets the target leave the grid.
    function automatic void aim_query(input bit outside);
        longint ncols, nrows, tc, tr, fx, fz, tx, tz, inv, px, pz;
        ncols = longint'(grid_dim(cols_reg, GRID_COLS));
        nrows = longint'(grid_dim(rows_reg, GRID_ROWS));
        if (outside) begin
            tc = longint'($urandom_range(0, 32'(ncols + 5))) - 3;
            tr = longint'($urandom_range(0, 32'(nrows + 5))) - 3;
        end else begin
            tc = longint'($urandom_range(0, 32'(ncols - 2)));
            tr = longint'($urandom_range(0, 32'(nrows - 2)));
        end
        fx = longint'($urandom_range(0, ONE_Q - 1));
        // hug the diagonal between the two triangles now and then
        if ($urandom_range(0, 3) == 0)
            fz = ONE_Q - fx + longint'($urandom_range(0, 2)) - 1;
        else
            fz = longint'($urandom_range(0, ONE_Q - 1));
        tx = tc * ONE_Q + fx;
        tz = tr * ONE_Q + fz;
        inv = longint'({40'd0, inv_reg});
        if (inv == 0) begin
            px = longint'($signed(24'($urandom)));
            pz = longint'($signed(24'($urandom)));
        end else begin
            px = ((tx - (ncols - 1) * (ONE_Q / 2)) * 256) / inv;
            pz = (((nrows - 1) * (ONE_Q / 2) - tz) * 256) / inv;
        end
        queue_query(fit_position(px), fit_position(pz));
    endfunction

    function automatic void random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            queue_write($urandom_range(0, 255), $urandom_range(0, 255), pick_height());
        else if (pick < 40)
            queue_write($urandom_range(0, grid_dim(rows_reg, GRID_ROWS) - 1),
                        $urandom_range(0, grid_dim(cols_reg, GRID_COLS) - 1), pick_height());
        else if (pick < 85)
            aim_query(1'b0);
        else if (pick < 93)
            aim_query(1'b1);
        else
            queue_query(24'($urandom), 24'($urandom));
    endfunction

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (terrain_items.size() != 0 || s_tvalid || heights_due.size() != 0);
        // writes give no result, so let any trailing one finish
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_NUM_COLS:          cols_reg = value[DIM_W-1:0];
            CFG_NUM_ROWS:          rows_reg = value[DIM_W-1:0];
            CFG_INV_CELL_DISTANCE: inv_reg  = value[INV_W-1:0];
            default: ;
        endcase
    endtask

    // n_items counts every transaction queued, corner fills included
    task automatic run_phase(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                             input logic [INV_W-1:0] inv, input int n_items,
                             input bit junk, input bit squeeze);
        logic [CFG_DATA_W-DIM_W-1:0] upper;
        int first_item;
        wait_idle();
        upper = junk ? (CFG_DATA_W-DIM_W)'($urandom) : '0;
        set_register(CFG_NUM_COLS, {upper, cols});
        upper = junk ? (CFG_DATA_W-DIM_W)'($urandom) : '0;
        set_register(CFG_NUM_ROWS, {upper, rows});
        set_register(CFG_INV_CELL_DISTANCE, inv);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_cnt++;
        // stall the result side long enough to back the block up
        if (squeeze)
            hold_requested++;
        first_item = items_queued;
        while (items_queued - first_item < n_items)
            random_item();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        settings_cnt = 1;

        // Directed: centre cell with opposing extremes, triangle edge, far corners
        queue_write(127, 127, 16'h7FFF);
        queue_write(127, 128, 16'h8000);
        queue_write(128, 127, 16'h0000);
        queue_write(128, 128, 16'hFFFF);
        queue_query(24'h000000, 24'h000000);
        queue_query(24'hFFFFFF, 24'h000001);
        queue_write(0, 0, 16'h7FFF);
        queue_write(0, 1, 16'h8000);
        queue_write(1, 0, 16'h8000);
        queue_write(1, 1, 16'h7FFF);
        queue_query(24'h800000, 24'h7FFFFF);
        queue_query(24'h7FFFFF, 24'h800000);
        queue_query(24'h7FFFFF, 24'h7FFFFF);
        queue_query(24'h800000, 24'h800000);
        queue_query(24'h000100, 24'hFFFF00);
        queue_write(255, 0, 16'h7FFF);
        queue_query(24'h800000, 24'h800000);

        run_phase(9'd256, 9'd256, 24'd6554, 150, 1'b0, 1'b0);
        run_phase(9'd2, 9'd2, 24'd65536, 120, 1'b0, 1'b0);
        run_phase(9'd0, 9'd1, 24'd1, 80, 1'b1, 1'b0);
        run_phase(9'd511, 9'd300, 24'hFFFFFF, 150, 1'b1, 1'b0);
        run_phase(9'd17, 9'd9, 24'd0, 60, 1'b0, 1'b0);
        run_phase(9'd256, 9'd256, 24'd1 << $urandom_range(12, 20), 200, 1'b0, 1'b1);
        repeat (4)
            run_phase(9'($urandom_range(2, 256)), 9'($urandom_range(2, 256)),
                      24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 16)),
                      160, 1'b1, 1'b0);
        wait_idle();

        $display("covered %0d height writes and %0d queries over %0d grid settings",
                 writes_seen, queries_seen, settings_cnt);
        $display("queries clamped %0d, lower-right %0d, saturated %0d",
                 clamped_seen, lower_seen, sat_seen);
        if (mismatch_cnt == 0 && heights_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
